### hdl/rtcux_pkg.sv
// ----------------------------------------------------------------------------
// rtcux_pkg
// Shared types, constants and helper functions for the clock-sample to
// epoch-seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcux_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0]  SEC_MAX       = 8'd59;
   localparam logic [7:0]  MIN_MAX       = 8'd59;
   localparam logic [7:0]  HOUR_MAX      = 8'd23;
   localparam logic [7:0]  DAY_MAX       = 8'd31;
   localparam logic [7:0]  MON_MAX       = 8'd12;
   localparam logic [7:0]  YEAR_PIVOT    = 8'd70;
   localparam logic [14:0] YEAR_BASE_19  = 15'd1900;
   localparam logic [14:0] YEAR_BASE_20  = 15'd2000;
   localparam logic [14:0] YEAR_EPOCH    = 15'd1970;
   localparam logic [24:0] EPOCH_DAYS    = 25'd719468;
   localparam logic [12:0] RECIP_25      = 13'd5243;
   localparam int          RECIP_SHIFT   = 17;
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
   localparam logic [16:0] SEC_PER_MIN   = 17'd60;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EARLY = 2'd2
   } status_type;

   // classified word passed from front to back
   typedef struct packed {
      status_type  status;
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [8:0]  offset;   // day of March-based year plus day - 1
      logic [14:0] yy;       // year, minus one for January and February
   } item_type;

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
   endfunction

   // days from March 1 to the first of the month
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### hdl/rtc_sample_to_unix_seconds.sv
// Path: an accepted req word is registered in the front register, then written
// to the queue, then passes four back stages. Throughput: one word per cycle
// while rsp_ready is high; the queue lets front and back stall apart.
// Reset clears the front register, the queue and the pipeline valid bits;
// no words are held across reset.
// ----------------------------------------------------------------------------
// rtc_sample_to_unix_seconds
// Converts one raw clock-chip sample to seconds since 1970-01-01 UTC.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_sample_to_unix_seconds
   import rtcux_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_raw_seconds,
   input  wire logic [7:0]  req_raw_minutes,
   input  wire logic [7:0]  req_raw_hours,
   input  wire logic [7:0]  req_raw_day,
   input  wire logic [7:0]  req_raw_month,
   input  wire logic [7:0]  req_raw_year,
   input  wire logic [7:0]  req_raw_century,
   input  wire logic        req_is_binary,
   input  wire logic        req_hour_24,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic [39:0]      rsp_unix_seconds,
   output logic [1:0]       rsp_status,
   output logic             rsp_valid,
   input  wire logic        rsp_ready
);

   item_type q_push_item, q_pop_item;
   logic     q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;

   rtcux_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_raw_seconds (req_raw_seconds),
      .req_raw_minutes (req_raw_minutes),
      .req_raw_hours   (req_raw_hours),
      .req_raw_day     (req_raw_day),
      .req_raw_month   (req_raw_month),
      .req_raw_year    (req_raw_year),
      .req_raw_century (req_raw_century),
      .req_is_binary   (req_is_binary),
      .req_hour_24     (req_hour_24),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .push_item       (q_push_item),
      .push_valid      (q_push_valid),
      .push_ready      (q_push_ready)
   );

   rtcux_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (q_push_item),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .pop_item   (q_pop_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready)
   );

   rtcux_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_item         (q_pop_item),
      .pop_valid        (q_pop_valid),
      .pop_ready        (q_pop_ready),
      .rsp_unix_seconds (rsp_unix_seconds),
      .rsp_status       (rsp_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready)
   );

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_unix_seconds == '0)
      else $error("rejected word carries nonzero seconds");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_pop_valid)
      else $error("pipeline or queue not empty after reset");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push_valid && q_push_ready |=> q_pop_valid)
      else $error("pushed word not visible at queue head");

endmodule

`default_nettype wire

### hdl/rtcux_front.sv
// ----------------------------------------------------------------------------
// rtcux_front
// Decodes one raw sample, range-checks it, forms the full year and
// registers the classified word for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcux_front
   import rtcux_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] req_raw_seconds,
   input  wire logic [7:0] req_raw_minutes,
   input  wire logic [7:0] req_raw_hours,
   input  wire logic [7:0] req_raw_day,
   input  wire logic [7:0] req_raw_month,
   input  wire logic [7:0] req_raw_year,
   input  wire logic [7:0] req_raw_century,
   input  wire logic       req_is_binary,
   input  wire logic       req_hour_24,
   input  wire logic       req_valid,
   output logic            req_ready,
   output item_type        push_item,
   output logic            push_valid,
   input  wire logic       push_ready
);

   logic       f_valid_ff, f_valid_in;
   item_type   f_item_ff, f_item_in;

   logic [7:0]  sec_d, min_d, day_d, mon_d, yr_d, cent_d, hour_d;
   logic [7:0]  hour_bcd;
   logic [6:0]  hour_lo;
   logic [7:0]  hour_f;
   logic        range_bad;
   logic [14:0] full_year;
   logic        accept;

   always_comb begin
      sec_d  = req_is_binary ? req_raw_seconds : bcd_to_bin(req_raw_seconds);
      min_d  = req_is_binary ? req_raw_minutes : bcd_to_bin(req_raw_minutes);
      day_d  = req_is_binary ? req_raw_day     : bcd_to_bin(req_raw_day);
      mon_d  = req_is_binary ? req_raw_month   : bcd_to_bin(req_raw_month);
      yr_d   = req_is_binary ? req_raw_year    : bcd_to_bin(req_raw_year);
      cent_d = req_is_binary ? req_raw_century : bcd_to_bin(req_raw_century);
      hour_bcd = bcd_to_bin({1'b0, req_raw_hours[6:0]});
      hour_d = req_is_binary ? req_raw_hours : {req_raw_hours[7], hour_bcd[6:0]};

      hour_lo = hour_d[6:0];
      if (req_hour_24) begin
         hour_f = hour_d;
      end else begin
         if (hour_d[7] && (hour_lo < 7'd12)) begin
            hour_lo = hour_lo + 7'd12;
         end else if (!hour_d[7] && (hour_lo == 7'd12)) begin
            hour_lo = 7'd0;
         end
         hour_f = {1'b0, hour_lo};
      end

      range_bad = (sec_d > SEC_MAX) || (min_d > MIN_MAX) || (hour_f > HOUR_MAX) ||
                  (day_d == 8'd0) || (day_d > DAY_MAX) ||
                  (mon_d == 8'd0) || (mon_d > MON_MAX);

      if (cent_d != 8'd0) begin
         full_year = 15'(cent_d) * 15'd100 + 15'(yr_d);
      end else if (yr_d >= YEAR_PIVOT) begin
         full_year = YEAR_BASE_19 + 15'(yr_d);
      end else begin
         full_year = YEAR_BASE_20 + 15'(yr_d);
      end

      if (range_bad) begin
         f_item_in.status = STATUS_RANGE;
      end else if (full_year < YEAR_EPOCH) begin
         f_item_in.status = STATUS_EARLY;
      end else begin
         f_item_in.status = STATUS_OK;
      end
      f_item_in.sec    = sec_d[5:0];
      f_item_in.min    = min_d[5:0];
      f_item_in.hour   = hour_f[4:0];
      f_item_in.offset = month_start(mon_d[3:0]) + 9'(day_d[4:0]) - 9'd1;
      f_item_in.yy     = (mon_d <= 8'd2) ? full_year - 15'd1 : full_year;
   end

   assign req_ready  = !f_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = f_valid_ff;
   assign push_item  = f_item_ff;

   always_comb begin
      f_valid_in = f_valid_ff;
      if (accept) begin
         f_valid_in = 1'b1;
      end else if (push_ready) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rtcux_queue.sv
// ----------------------------------------------------------------------------
// rtcux_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcux_queue
   import rtcux_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  item_type  push_item,
   input  wire logic push_valid,
   output logic      push_ready,
   output item_type  pop_item,
   output logic      pop_valid,
   input  wire logic pop_ready
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### hdl/rtcux_back.sv
// ----------------------------------------------------------------------------
// rtcux_back
// Four-stage pipeline: day count from year and month, then seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcux_back
   import rtcux_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  item_type    pop_item,
   input  wire logic   pop_valid,
   output logic        pop_ready,
   output logic [39:0] rsp_unix_seconds,
   output logic [1:0]  rsp_status,
   output logic        rsp_valid,
   input  wire logic   rsp_ready
);

   logic        ce;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;

   status_type  s1_status_ff;
   logic [23:0] s1_y365_ff, s1_y365_in;
   logic [12:0] s1_yq_ff, s1_yq_in;
   logic [25:0] s1_q100_ff, s1_q100_in;
   logic [23:0] s1_q400_ff, s1_q400_in;
   logic [8:0]  s1_off_ff;
   logic [16:0] s1_tod_ff, s1_tod_in;

   status_type  s2_status_ff;
   logic [23:0] s2_days_ff, s2_days_in;
   logic [24:0] day_sum;
   logic [16:0] s2_tod_ff;

   status_type  s3_status_ff;
   logic [39:0] s3_prod_ff, s3_prod_in;
   logic [16:0] s3_tod_ff;

   status_type  rsp_status_ff;
   logic [39:0] rsp_unix_ff, rsp_unix_in;

   assign ce        = !v4_ff || rsp_ready;
   assign pop_ready = ce;

   always_comb begin
      s1_y365_in = 24'(pop_item.yy) * 24'd365;
      s1_yq_in   = pop_item.yy[14:2];
      s1_q100_in = 26'(pop_item.yy[14:2]) * 26'(RECIP_25);
      s1_q400_in = 24'(pop_item.yy[14:4]) * 24'(RECIP_25);
      s1_tod_in  = 17'(pop_item.hour) * SEC_PER_HOUR + 17'(pop_item.min) * SEC_PER_MIN
                   + 17'(pop_item.sec);

      day_sum = 25'(s1_y365_ff) + 25'(s1_yq_ff) - 25'(s1_q100_ff[25:RECIP_SHIFT])
                + 25'(s1_q400_ff[23:RECIP_SHIFT]) + 25'(s1_off_ff) - EPOCH_DAYS;
      s2_days_in = day_sum[23:0];

      s3_prod_in  = 40'(s2_days_ff) * 40'(SEC_PER_DAY);
      rsp_unix_in = (s3_status_ff == STATUS_OK) ? s3_prod_ff + 40'(s3_tod_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= pop_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_status_ff  <= pop_item.status;
         s1_y365_ff    <= s1_y365_in;
         s1_yq_ff      <= s1_yq_in;
         s1_q100_ff    <= s1_q100_in;
         s1_q400_ff    <= s1_q400_in;
         s1_off_ff     <= pop_item.offset;
         s1_tod_ff     <= s1_tod_in;
         s2_status_ff  <= s1_status_ff;
         s2_days_ff    <= s2_days_in;
         s2_tod_ff     <= s1_tod_ff;
         s3_status_ff  <= s2_status_ff;
         s3_prod_ff    <= s3_prod_in;
         s3_tod_ff     <= s2_tod_ff;
         rsp_status_ff <= s3_status_ff;
         rsp_unix_ff   <= rsp_unix_in;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_unix_seconds = rsp_unix_ff;

endmodule

`default_nettype wire
